// ----- hw/rtl/pil_pkg.sv -----
package pil_pkg;

    localparam int DEPTH_DEFAULT = 128;

    localparam int CMD_W = 2;
    localparam int POS_W = 8;
    localparam int VAL_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ----- hw/rtl/position_indexed_list.sv -----
// Channel   Signals                                          Handshake
// command   i_command, i_position, i_item_value              start high while busy low
// result    o_status, o_read_value, o_list_length            o_strobe, one cycle, no stall
//
// Every command gives one result word, marked by o_strobe.
// Insert at position p copies entries p onward up one slot, walking downward from the top
// one entry per cycle through the single RAM, then writes the new item into slot p.
// Delete copies the entries after p down one slot the same way; read waits on the RAM read.
// Errors, append and deleting the last entry are answered straight from idle.
// A new command may be accepted in the cycle its predecessor's result is shown.
// Reset clears the length and the state; o_list_length and the entry store are not cleared.
module position_indexed_list #(
    parameter int DEPTH = pil_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [pil_pkg::CMD_W-1:0]        i_command,
    input  logic [pil_pkg::POS_W-1:0]        i_position,
    input  logic signed [pil_pkg::VAL_W-1:0] i_item_value,
    output logic                             o_strobe,
    output logic [pil_pkg::STAT_W-1:0]       o_status,
    output logic signed [pil_pkg::VAL_W-1:0] o_read_value,
    output logic [pil_pkg::LEN_W-1:0]        o_list_length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > pil_pkg::POS_W) ? CW : pil_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_END,
        S_PUT,
        S_DEL,
        S_DEL_END,
        S_RD,
        S_RD_END
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_ra;
    logic [AW-1:0] r_last;
    logic [AW-1:0] r_wa;
    logic          r_wvalid;
    logic [pil_pkg::VAL_W-1:0] r_val;

    logic                               r_strobe;
    logic [pil_pkg::STAT_W-1:0]         r_status;
    logic [pil_pkg::VAL_W-1:0]          r_read_value;
    logic [pil_pkg::LEN_W-1:0]          r_len;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [pil_pkg::VAL_W-1:0] ram_wdata;
    logic [pil_pkg::VAL_W-1:0] ram_q;

    logic            accept;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] pm1_x;
    logic            pos_nz;
    logic            ins_pos_ok;
    logic            acc_pos_ok;
    logic            is_full;
    logic            is_append;
    logic            is_del_last;
    logic [AW-1:0]   pm1_a;
    logic [AW-1:0]   cnt_a;
    logic [AW-1:0]   cm1_a;

    function automatic logic [pil_pkg::LEN_W-1:0] LEN_W_CAST(input logic [CW-1:0] c);
        LEN_W_CAST = pil_pkg::LEN_W'(c);
    endfunction

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);

    assign pos_x = CMPW'(i_position);
    assign cnt_x = CMPW'(r_count);
    assign pm1_x = pos_x - CMPW'(1);
    assign pos_nz = (i_position != '0);
    assign ins_pos_ok = pos_nz && (pos_x <= cnt_x + CMPW'(1));
    assign acc_pos_ok = pos_nz && (pos_x <= cnt_x);
    assign is_full = (r_count == CW'(DEPTH));
    assign is_append = (pos_x == cnt_x + CMPW'(1));
    assign is_del_last = (pos_x == cnt_x);
    // These truncations only matter on paths where the position is already known valid.
    assign pm1_a = AW'(pm1_x);
    assign cnt_a = AW'(cnt_x);
    assign cm1_a = AW'(cnt_x - CMPW'(1));

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_q;
        case (r_state)
            S_IDLE: begin
                if (accept && i_command == pil_pkg::CMD_INSERT && ins_pos_ok && !is_full
                    && is_append) begin
                    ram_we = 1'b1;
                    ram_waddr = cnt_a;
                    ram_wdata = i_item_value;
                end
            end
            S_INS, S_DEL: begin
                ram_we = r_wvalid;
            end
            S_INS_END, S_DEL_END: begin
                ram_we = 1'b1;
            end
            S_PUT: begin
                ram_we = 1'b1;
                ram_waddr = r_last;
                ram_wdata = r_val;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    pil_ram #(
        .WIDTH(pil_pkg::VAL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_ra),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_strobe <= 1'b0;
            r_wvalid <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_val <= i_item_value;
                        r_wvalid <= 1'b0;
                        r_status <= pil_pkg::ST_OK;
                        r_read_value <= '0;
                        r_len <= LEN_W_CAST(r_count);
                        case (i_command)
                            pil_pkg::CMD_INSERT: begin
                                if (!ins_pos_ok) begin
                                    r_status <= pil_pkg::ST_RANGE;
                                    r_strobe <= 1'b1;
                                end else if (is_full) begin
                                    r_status <= pil_pkg::ST_FULL;
                                    r_strobe <= 1'b1;
                                end else if (is_append) begin
                                    r_count <= r_count + CW'(1);
                                    r_len <= LEN_W_CAST(r_count + CW'(1));
                                    r_strobe <= 1'b1;
                                end else begin
                                    // Copy downward from the top entry to the insert slot.
                                    r_ra <= cm1_a;
                                    r_last <= pm1_a;
                                    r_state <= S_INS;
                                end
                            end
                            pil_pkg::CMD_DELETE: begin
                                if (!acc_pos_ok) begin
                                    r_status <= pil_pkg::ST_RANGE;
                                    r_strobe <= 1'b1;
                                end else if (is_del_last) begin
                                    r_count <= r_count - CW'(1);
                                    r_len <= LEN_W_CAST(r_count - CW'(1));
                                    r_strobe <= 1'b1;
                                end else begin
                                    // Copy upward from the entry after the hole to the top.
                                    r_ra <= AW'(pos_x);
                                    r_last <= cm1_a;
                                    r_state <= S_DEL;
                                end
                            end
                            pil_pkg::CMD_READ: begin
                                if (!acc_pos_ok) begin
                                    r_status <= pil_pkg::ST_RANGE;
                                    r_strobe <= 1'b1;
                                end else begin
                                    r_ra <= pm1_a;
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                r_status <= pil_pkg::ST_RANGE;
                                r_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                S_INS: begin
                    r_wa <= r_ra + AW'(1);
                    r_wvalid <= 1'b1;
                    if (r_ra == r_last) begin
                        r_state <= S_INS_END;
                    end else begin
                        r_ra <= r_ra - AW'(1);
                    end
                end
                S_INS_END: begin
                    r_wvalid <= 1'b0;
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    r_count <= r_count + CW'(1);
                    r_len <= LEN_W_CAST(r_count + CW'(1));
                    r_strobe <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DEL: begin
                    r_wa <= r_ra - AW'(1);
                    r_wvalid <= 1'b1;
                    if (r_ra == r_last) begin
                        r_state <= S_DEL_END;
                    end else begin
                        r_ra <= r_ra + AW'(1);
                    end
                end
                S_DEL_END: begin
                    r_wvalid <= 1'b0;
                    r_count <= r_count - CW'(1);
                    r_len <= LEN_W_CAST(r_count - CW'(1));
                    r_strobe <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_RD_END;
                end
                S_RD_END: begin
                    r_read_value <= ram_q;
                    r_strobe <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_status = r_status;
    assign o_read_value = r_read_value;
    assign o_list_length = r_len;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list length above capacity");

    a_accept_reacts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_strobe))
        else $error("accepted command neither busy nor answered");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != pil_pkg::ST_OK) |-> (r_count == $past(r_count)))
        else $error("rejected command changed the length");

    a_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != pil_pkg::ST_OK) |-> (o_read_value == '0))
        else $error("rejected command returned a nonzero value");

endmodule

// ----- hw/rtl/pil_ram.sv -----
module pil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/tb.sv -----
module tb;
    import pil_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int RANDOM_WORDS = 1740;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int MODE_GROW = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]  list_length;
    } list_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  item_value;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
        logic [LEN_W-1:0]  list_length;
    } step_row_t;

    localparam int ROW_COUNT = 31;
    // Rows from this index on run against a list that has been filled to capacity.
    localparam int FILL_AT = 17;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         i_command = CMD_READ;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [VAL_W-1:0]  i_item_value = '0;
    logic                     o_strobe;
    logic [STAT_W-1:0]        o_status;
    logic signed [VAL_W-1:0]  o_read_value;
    logic [LEN_W-1:0]         o_list_length;

    logic [VAL_W-1:0] list_store [DEPTH];
    int               list_count = 0;
    list_result_t     pending_results [$];
    int               fail_count = 0;
    step_row_t        directed_rows [ROW_COUNT];

    position_indexed_list #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_list_length(o_list_length)
    );

    always #1 i_clk = ~i_clk;

    function automatic list_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [VAL_W-1:0] val);
        list_result_t r;
        int p;
        p = int'(pos);
        r.status = ST_OK;
        r.read_value = '0;
        case (cmd)
            CMD_INSERT: begin
                // The position is judged before the capacity.
                if (p < 1 || p > list_count + 1) begin
                    r.status = ST_RANGE;
                end else if (list_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_count; i >= p; i--)
                        list_store[i] = list_store[i - 1];
                    list_store[p - 1] = val;
                    list_count++;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    for (int i = p; i < list_count; i++)
                        list_store[i - 1] = list_store[i];
                    list_count--;
                end
            end
            CMD_READ: begin
                if (p < 1 || p > list_count)
                    r.status = ST_RANGE;
                else
                    r.read_value = list_store[p - 1];
            end
            default: r.status = ST_RANGE;
        endcase
        r.list_length = LEN_W'(list_count);
        return r;
    endfunction

    // Leaves start high after the accept so that a following word can go back to back.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                         input logic [VAL_W-1:0] val, input logic typed,
                         input list_result_t typed_result);
        list_result_t predicted;
        start <= 1'b1;
        i_command <= cmd;
        i_position <= pos;
        i_item_value <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = apply_command(cmd, pos, val);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results;
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(input int mode);
        int roll;
        int ins_limit;
        int del_limit;
        roll = $urandom_range(0, 99);
        ins_limit = (mode == MODE_GROW) ? 62 : (mode == MODE_SHRINK) ? 20 : 40;
        del_limit = (mode == MODE_GROW) ? 78 : 72;
        if (roll < 2)
            return CMD_UNUSED;
        else if (roll < ins_limit)
            return CMD_INSERT;
        else if (roll < del_limit)
            return CMD_DELETE;
        else
            return CMD_READ;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [CMD_W-1:0] cmd);
        int limit;
        limit = (cmd == CMD_INSERT) ? list_count + 1 : list_count;
        if (limit == 0 || $urandom_range(0, 99) < 12)
            return POS_W'($urandom_range(0, 255));
        return POS_W'($urandom_range(1, limit));
    endfunction

    initial begin
        directed_rows = '{
            '{CMD_READ,   8'd1,   32'd0,          1'b1, ST_RANGE, 32'd0,          8'd0},
            '{CMD_DELETE, 8'd1,   32'd0,          1'b1, ST_RANGE, 32'd0,          8'd0},
            '{CMD_INSERT, 8'd0,   32'd5,          1'b1, ST_RANGE, 32'd0,          8'd0},
            '{CMD_INSERT, 8'd2,   32'd5,          1'b1, ST_RANGE, 32'd0,          8'd0},
            '{CMD_INSERT, 8'd1,   32'h8000_0000,  1'b1, ST_OK,    32'd0,          8'd1},
            '{CMD_INSERT, 8'd2,   32'h7fff_ffff,  1'b1, ST_OK,    32'd0,          8'd2},
            '{CMD_INSERT, 8'd1,   32'hffff_ffff,  1'b1, ST_OK,    32'd0,          8'd3},
            '{CMD_READ,   8'd1,   32'd0,          1'b1, ST_OK,    32'hffff_ffff,  8'd3},
            '{CMD_READ,   8'd3,   32'd0,          1'b1, ST_OK,    32'h7fff_ffff,  8'd3},
            '{CMD_READ,   8'd2,   32'd0,          1'b1, ST_OK,    32'h8000_0000,  8'd3},
            '{CMD_READ,   8'd4,   32'd0,          1'b1, ST_RANGE, 32'd0,          8'd3},
            '{CMD_UNUSED, 8'd1,   32'hdead_beef,  1'b1, ST_RANGE, 32'd0,          8'd3},
            '{CMD_DELETE, 8'd2,   32'd0,          1'b1, ST_OK,    32'd0,          8'd2},
            '{CMD_DELETE, 8'd2,   32'd0,          1'b1, ST_OK,    32'd0,          8'd1},
            '{CMD_READ,   8'd1,   32'd0,          1'b1, ST_OK,    32'hffff_ffff,  8'd1},
            '{CMD_READ,   8'd255, 32'd0,          1'b1, ST_RANGE, 32'd0,          8'd1},
            '{CMD_INSERT, 8'd255, 32'd9,          1'b1, ST_RANGE, 32'd0,          8'd1},
            '{CMD_INSERT, 8'd1,   32'd1,          1'b1, ST_FULL,  32'd0,          8'd128},
            '{CMD_INSERT, 8'd129, 32'd1,          1'b1, ST_FULL,  32'd0,          8'd128},
            '{CMD_INSERT, 8'd130, 32'd1,          1'b1, ST_RANGE, 32'd0,          8'd128},
            '{CMD_INSERT, 8'd0,   32'd1,          1'b1, ST_RANGE, 32'd0,          8'd128},
            '{CMD_READ,   8'd129, 32'd0,          1'b1, ST_RANGE, 32'd0,          8'd128},
            '{CMD_READ,   8'd128, 32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
            '{CMD_DELETE, 8'd128, 32'd0,          1'b1, ST_OK,    32'd0,          8'd127},
            '{CMD_DELETE, 8'd1,   32'd0,          1'b1, ST_OK,    32'd0,          8'd126},
            '{CMD_READ,   8'd1,   32'd0,          1'b0, ST_OK,    32'd0,          8'd0},
            '{CMD_INSERT, 8'd127, 32'h1234_5678,  1'b1, ST_OK,    32'd0,          8'd127},
            '{CMD_READ,   8'd127, 32'd0,          1'b1, ST_OK,    32'h1234_5678,  8'd127},
            '{CMD_INSERT, 8'd64,  32'd0,          1'b1, ST_OK,    32'd0,          8'd128},
            '{CMD_READ,   8'd64,  32'd0,          1'b1, ST_OK,    32'd0,          8'd128},
            '{CMD_READ,   8'd65,  32'd0,          1'b0, ST_OK,    32'd0,          8'd0}
        };
    end

    always @(posedge i_clk) begin
        list_result_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result word with no command pending: status %0d length %0d",
                       o_status, o_list_length);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %h, actual %h", want.read_value, o_read_value);
                    fail_count++;
                end
                if (o_list_length !== want.list_length) begin
                    $error("list_length: expected %0d, actual %0d",
                           want.list_length, o_list_length);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int sent;
        int mode;
        int next_switch;
        int burst;
        logic [CMD_W-1:0] cmd;
        list_result_t row_result;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < ROW_COUNT; r++) begin
            if (r == FILL_AT) begin
                // Appends go back to back until the store is at capacity.
                while (list_count < DEPTH)
                    issue(CMD_INSERT, POS_W'(list_count + 1), $urandom, 1'b0, '0);
            end
            row_result.status = directed_rows[r].status;
            row_result.read_value = directed_rows[r].read_value;
            row_result.list_length = directed_rows[r].list_length;
            issue(directed_rows[r].command, directed_rows[r].position,
                  directed_rows[r].item_value, directed_rows[r].typed, row_result);
            pause($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 3));
        end

        sent = 0;
        next_switch = 0;
        mode = MODE_GROW;
        while (sent < RANDOM_WORDS) begin
            if (sent >= next_switch) begin
                // Let the list settle completely before a new phase starts.
                wait_for_results();
                mode = $urandom_range(MODE_GROW, MODE_MIXED);
                next_switch = sent + $urandom_range(150, 350);
            end
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
                cmd = pick_command(mode);
                issue(cmd, pick_position(cmd), $urandom, 1'b0, '0);
                sent++;
            end
            pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25));
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pil_pkg.sv
hw/rtl/pil_ram.sv
hw/rtl/position_indexed_list.sv
dv/tb.sv
